[design/assert_macros.svh]
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert a property, clocked on clk with async low reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: label");
// Assert an implication under the same clocking
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");
`endif

[design/rsp_pkg.sv]
// ----------------------------------------------------------------------------
// rsp_pkg
// Types and constants for the streaming RESP byte parser.
// ----------------------------------------------------------------------------
`default_nettype none
package rsp_pkg;
  typedef enum logic [2:0] {
    TY_INT = 3'd0, TY_DBL = 3'd1, TY_BOOL = 3'd2, TY_NULL = 3'd3,
    TY_SIMPLE = 3'd4, TY_BULK = 3'd5, TY_ARRAY = 3'd6
  } elem_type_e;
  typedef enum logic [1:0] {
    RK_PAYLOAD = 2'd0, RK_COMPLETE = 2'd1, RK_ERROR = 2'd2
  } result_kind_e;
  typedef enum logic [1:0] {
    ERR_UNKNOWN = 2'd0, ERR_TOKEN = 2'd1, ERR_BULK_LEN = 2'd2
  } fault_code_e;
  typedef enum logic [1:0] {
    BP_LENGTH = 2'd0, BP_DATA = 2'd1, BP_TERM = 2'd2
  } bulk_phase_e;
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;
  localparam int unsigned LEN_BITS = 30;
  localparam logic [LEN_BITS-1:0] BULK_LEN_RESET = 30'd536870912;
  localparam logic [7:0] CH_PLUS = 8'h2B, CH_MINUS = 8'h2D, CH_COLON = 8'h3A,
                         CH_HASH = 8'h23, CH_COMMA = 8'h2C, CH_UNDER = 8'h5F,
                         CH_STAR = 8'h2A, CH_DOLLAR = 8'h24, CH_CR = 8'h0D,
                         CH_LF = 8'h0A, CH_DOT = 8'h2E, CH_0 = 8'h30, CH_9 = 8'h39;
endpackage
`default_nettype wire

[design/resp_stream_parser_core.sv]
// ----------------------------------------------------------------------------
// resp_stream_parser_core
// Byte-serial RESP message parser with sticky error and element counting.
// ----------------------------------------------------------------------------
// The result of an accepted beat is written to the output register on the edge that accepts it.
// Throughput: one beat per cycle; the output register accepts a new beat
// whenever it is empty or being drained in the same cycle.
// The parse step is one decode plus a multiply by ten on the accumulators.
// Reset: parser state takes its reset values, output valid clears; max_bulk_length
// returns to 2^29. A restart beat clears the parser but keeps the register.
`default_nettype none
module resp_stream_parser_core
  import rsp_pkg::*;
#(
  parameter int MAX_FRACTION_DIGITS = 18,
  parameter int ELEMENT_COUNT_BITS  = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [LEN_BITS-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                operation_i,
  input  wire logic [7:0]          in_byte_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [1:0]               result_kind_o,
  output logic [2:0]               value_type_o,
  output logic signed [63:0]       integer_value_o,
  output logic [59:0]              fraction_value_o,
  output logic [4:0]               fraction_digits_o,
  output logic                     boolean_value_o,
  output logic [7:0]               string_byte_o,
  output logic [1:0]               fault_code_o,
  output logic                     message_done_o
);
  localparam int CB = ELEMENT_COUNT_BITS;
  localparam logic [4:0] MAXFD = 5'(MAX_FRACTION_DIGITS);
  localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};

  logic [LEN_BITS-1:0] max_len_q;
  logic act_q, act_d, first_q, first_d, neg_q, neg_d, infr_q, infr_d;
  logic bl_q, bl_d, fin_q, fin_d, err_q, err_d;
  elem_type_e ty_q, ty_d;
  logic [63:0] acc_q, acc_d;
  logic [59:0] fra_q, fra_d;
  logic [4:0]  fcnt_q, fcnt_d;
  bulk_phase_e bp_q, bp_d;
  logic [LEN_BITS-1:0] brem_q, brem_d;
  logic [1:0] le_q, le_d;
  logic [CB-1:0] exp_q, exp_d, cmp_q, cmp_d;

  logic emit, accept;
  logic [1:0] rk_d, ec_d;
  logic [2:0] vt_d;
  logic [63:0] iv_d;
  logic [59:0] fv_d;
  logic [4:0] fd_d;
  logic bv_d, md_d;
  logic [7:0] sb_d;

  assign in_stall_o = out_valid_o && out_stall_i;
  assign accept = in_valid_i && !in_stall_o;

  logic [3:0] dig;
  logic is_dig;
  logic [63:0] acc10, sv;
  logic [67:0] acc10w;
  logic [63:0] bcap;
  logic bsat, asat;
  logic [CB-1:0] cmp_inc;
  assign dig    = in_byte_i[3:0];
  assign is_dig = in_byte_i >= CH_0 && in_byte_i <= CH_9;
  assign acc10w = (68'(acc_q) << 3) + (68'(acc_q) << 1) + 68'(dig);
  assign acc10  = acc10w[63:0];
  assign sv     = neg_q ? 64'(0) - acc_q : acc_q;
  assign bcap   = 64'(max_len_q) + 64'd1;
  assign bsat   = (64'(dig) <= bcap) && (acc10w > 68'(bcap));
  assign asat   = acc10w > 68'(CNT_MAX);
  assign cmp_inc = cmp_q + 1'b1;

  always_comb begin
    act_d = act_q; first_d = first_q; neg_d = neg_q; infr_d = infr_q;
    bl_d = bl_q; fin_d = fin_q; err_d = err_q; ty_d = ty_q; acc_d = acc_q;
    fra_d = fra_q; fcnt_d = fcnt_q; bp_d = bp_q; brem_d = brem_q; le_d = le_q;
    exp_d = exp_q; cmp_d = cmp_q;
    emit = 1'b0; rk_d = RK_PAYLOAD; ec_d = ERR_UNKNOWN; vt_d = TY_INT; iv_d = '0;
    fv_d = '0; fd_d = '0; bv_d = 1'b0; md_d = 1'b0; sb_d = '0;
    if (operation_i == OP_RESTART) begin
      act_d = 1'b0; first_d = 1'b0; neg_d = 1'b0; infr_d = 1'b0; bl_d = 1'b0;
      fin_d = 1'b0; err_d = 1'b0; ty_d = TY_INT; acc_d = '0; fra_d = '0;
      fcnt_d = '0; bp_d = BP_LENGTH; brem_d = '0; le_d = 2'd2;
      exp_d = CB'(1); cmp_d = '0;
    end else if (!(err_q || fin_q)) begin
      logic do_fail, do_comp, do_pay;
      logic [1:0] fcode;
      do_fail = 1'b0; do_comp = 1'b0; do_pay = 1'b0; fcode = ERR_TOKEN;
      if (!act_q) begin
        act_d = 1'b1; first_d = 1'b1; neg_d = 1'b0; acc_d = '0; infr_d = 1'b0;
        fra_d = '0; fcnt_d = '0; bl_d = 1'b0; bp_d = BP_LENGTH; brem_d = '0;
        le_d = 2'd2;
        case (in_byte_i)
          CH_COLON:  ty_d = TY_INT;
          CH_COMMA:  ty_d = TY_DBL;
          CH_HASH:   ty_d = TY_BOOL;
          CH_UNDER:  ty_d = TY_NULL;
          CH_PLUS:   ty_d = TY_SIMPLE;
          CH_DOLLAR: ty_d = TY_BULK;
          CH_STAR:   ty_d = TY_ARRAY;
          default: begin
            do_fail = 1'b1; fcode = ERR_UNKNOWN; act_d = 1'b0; first_d = first_q;
          end
        endcase
      end else begin
        first_d = 1'b0;
        case (ty_q)
          TY_INT: begin
            if (first_q && in_byte_i == CH_MINUS) neg_d = 1'b1;
            else if (in_byte_i == CH_CR) ;
            else if (in_byte_i == CH_LF) do_comp = 1'b1;
            else if (!is_dig) do_fail = 1'b1;
            else acc_d = acc10;
          end
          TY_DBL: begin
            if (first_q && in_byte_i == CH_MINUS) neg_d = 1'b1;
            else if (in_byte_i == CH_CR) ;
            else if (in_byte_i == CH_LF) do_comp = 1'b1;
            else if (!infr_q && (in_byte_i == CH_DOT || in_byte_i == CH_COMMA))
              infr_d = 1'b1;
            else if (!is_dig) do_fail = 1'b1;
            else if (infr_q) begin
              if (fcnt_q < MAXFD) begin
                fra_d = (fra_q << 3) + (fra_q << 1) + 60'(dig);
                fcnt_d = fcnt_q + 1'b1;
              end
            end else acc_d = acc10;
          end
          TY_BOOL: begin
            if (first_q) begin
              if (in_byte_i == "1" || in_byte_i == "t" || in_byte_i == "T") bl_d = 1'b1;
              else if (in_byte_i == "0" || in_byte_i == "f" || in_byte_i == "F")
                bl_d = 1'b0;
              else do_fail = 1'b1;
            end else if (in_byte_i == CH_LF) do_comp = 1'b1;
          end
          TY_NULL: begin
            if (in_byte_i == CH_CR) ;
            else if (in_byte_i == CH_LF) do_comp = 1'b1;
            else do_fail = 1'b1;
          end
          TY_SIMPLE: begin
            if (le_q == 2'd1) begin
              if (in_byte_i == CH_LF) do_comp = 1'b1;
              else do_fail = 1'b1;
            end else if (in_byte_i == CH_CR) le_d = 2'd1;
            else if (in_byte_i == CH_LF) do_comp = 1'b1;
            else do_pay = 1'b1;
          end
          TY_BULK: begin
            case (bp_q)
              BP_LENGTH: begin
                if (first_q && in_byte_i == CH_MINUS) begin
                  do_fail = 1'b1; fcode = ERR_BULK_LEN;
                end else if (in_byte_i == CH_CR) ;
                else if (in_byte_i == CH_LF) begin
                  if (acc_q > 64'(max_len_q)) begin
                    do_fail = 1'b1; fcode = ERR_BULK_LEN;
                  end else begin
                    brem_d = acc_q[LEN_BITS-1:0];
                    bp_d = (acc_q != 0) ? BP_DATA : BP_TERM;
                  end
                end else if (!is_dig) do_fail = 1'b1;
                else if (bsat) acc_d = bcap;
                else acc_d = acc10;
              end
              BP_DATA: begin
                brem_d = brem_q - 1'b1;
                if (brem_d == '0) bp_d = BP_TERM;
                do_pay = 1'b1;
              end
              default: begin
                if (in_byte_i == CH_CR || in_byte_i == CH_LF) begin
                  le_d = (le_q != 0) ? le_q - 1'b1 : le_q;
                  if (le_d == 2'd0) do_comp = 1'b1;
                end else do_fail = 1'b1;
              end
            endcase
          end
          TY_ARRAY: begin
            if (in_byte_i == CH_CR) ;
            else if (in_byte_i == CH_LF) begin
              exp_d = acc_q[CB-1:0];
              act_d = 1'b0;
              if (cmp_q == acc_q[CB-1:0]) fin_d = 1'b1;
            end else if (!is_dig) do_fail = 1'b1;
            else if (asat) acc_d = 64'(CNT_MAX);
            else acc_d = acc10;
          end
          default: do_fail = 1'b1;
        endcase
      end
      if (do_fail) begin
        err_d = 1'b1; act_d = 1'b0; emit = 1'b1; rk_d = RK_ERROR; ec_d = fcode;
      end else if (do_comp) begin
        cmp_d = cmp_inc; act_d = 1'b0; emit = 1'b1; rk_d = RK_COMPLETE;
        vt_d = ty_q;
        md_d = fin_q || (cmp_inc == exp_q);
        fin_d = md_d;
        if (ty_q == TY_INT) iv_d = sv;
        if (ty_q == TY_DBL) begin
          iv_d = sv; fv_d = fra_q; fd_d = fcnt_q; bv_d = neg_q;
        end
        if (ty_q == TY_BOOL) bv_d = bl_q;
      end else if (do_pay) begin
        emit = 1'b1; rk_d = RK_PAYLOAD; vt_d = ty_q; sb_d = in_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= BULK_LEN_RESET;
      act_q <= 1'b0; first_q <= 1'b0; neg_q <= 1'b0; infr_q <= 1'b0;
      bl_q <= 1'b0; fin_q <= 1'b0; err_q <= 1'b0; ty_q <= TY_INT;
      acc_q <= '0; fra_q <= '0; fcnt_q <= '0; bp_q <= BP_LENGTH; brem_q <= '0;
      le_q <= 2'd2; exp_q <= CB'(1); cmp_q <= '0; out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) max_len_q <= cfg_wdata_i;
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      if (accept) begin
        act_q <= act_d; first_q <= first_d; neg_q <= neg_d; infr_q <= infr_d;
        bl_q <= bl_d; fin_q <= fin_d; err_q <= err_d; ty_q <= ty_d;
        acc_q <= acc_d; fra_q <= fra_d; fcnt_q <= fcnt_d; bp_q <= bp_d;
        brem_q <= brem_d; le_q <= le_d; exp_q <= exp_d; cmp_q <= cmp_d;
        if (emit) out_valid_o <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      result_kind_o <= rk_d; value_type_o <= vt_d; integer_value_o <= iv_d;
      fraction_value_o <= fv_d; fraction_digits_o <= fd_d;
      boolean_value_o <= bv_d; string_byte_o <= sb_d; fault_code_o <= ec_d;
      message_done_o <= md_d;
    end
  end
endmodule
`default_nettype wire

[design/rsp_checker.sv]
// ----------------------------------------------------------------------------
// rsp_checker
// Port-level checks on the parser output channel.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module rsp_checker
  import rsp_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [1:0] result_kind_o,
  input wire logic [1:0] fault_code_o,
  input wire logic       message_done_o
);
  `ASSERT_IMPL(a_stall_only_full, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
               ##1 (out_valid_o && $stable(result_kind_o)))
  `ASSERT_IMPL(a_kind_legal, clk_i, rst_ni, out_valid_o,
               result_kind_o == RK_PAYLOAD || result_kind_o == RK_COMPLETE ||
               result_kind_o == RK_ERROR)
  `ASSERT_IMPL(a_err_code, clk_i, rst_ni, out_valid_o && result_kind_o == RK_ERROR,
               fault_code_o != 2'd3 && !message_done_o)
endmodule
bind resp_stream_parser_core rsp_checker u_rsp_checker (.*);
`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for resp_stream_parser_core: a queue of beats feeds a
// clocked driver, a behavioural parser predicts each result, and a monitor
// compares every output beat field by field under several idling phases.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  import rsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       op;
    logic [7:0] b;
  } beat_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         vtype;
    logic signed [63:0] ival;
    logic [59:0]        fval;
    logic [4:0]         fdig;
    logic               bval;
    logic [7:0]         sbyte;
    logic [1:0]         ecode;
    logic               done;
  } result_t;

  localparam logic [31:0] CNT_MASK = 32'hFFFF_FFFF;
  localparam int STALL_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [LEN_BITS-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic operation_i = OP_BYTE;
  logic [7:0] in_byte_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] result_kind_o;
  logic [2:0] value_type_o;
  logic signed [63:0] integer_value_o;
  logic [59:0] fraction_value_o;
  logic [4:0] fraction_digits_o;
  logic boolean_value_o;
  logic [7:0] string_byte_o;
  logic [1:0] fault_code_o;
  logic message_done_o;
  logic in_taken = 1'b0;

  resp_stream_parser_core dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // parser model state
  logic [29:0] max_len;
  logic active, first_byte, neg, in_frac, bool_v, err_l, msg_fin;
  elem_type_e ety;
  logic [63:0] acc, facc;
  logic [4:0] fcnt;
  bulk_phase_e bphase;
  logic [29:0] remain;
  logic [1:0] eol_left;
  logic [31:0] exp_elems, done_elems;

  beat_t   pending_beats[$];
  result_t expected_results[$];
  int send_idle_pct, recv_stall_pct;
  int failures = 0;
  int quiet_cycles = 0;

  function automatic logic [63:0] sat_mac(logic [63:0] a, logic [3:0] d, logic [63:0] cap);
    if (a > (cap - d) / 10) return cap;
    return a * 10 + d;
  endfunction

  function automatic logic is_dig(logic [7:0] b);
    return b >= CH_0 && b <= CH_9;
  endfunction

  task automatic clear_parser();
    active = 0; ety = TY_INT; first_byte = 0; neg = 0; acc = 0; in_frac = 0;
    facc = 0; fcnt = 0; bool_v = 0; bphase = BP_LENGTH; remain = 0; eol_left = 2;
    exp_elems = 1; done_elems = 0; msg_fin = 0; err_l = 0;
  endtask

  task automatic push_error(fault_code_e c);
    result_t r;
    r = '0; r.kind = RK_ERROR; r.ecode = c;
    err_l = 1; active = 0;
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic push_payload(logic [7:0] b);
    result_t r;
    r = '0; r.kind = RK_PAYLOAD; r.vtype = ety; r.sbyte = b;
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic push_complete();
    result_t r;
    logic [63:0] sv;
    sv = neg ? -acc : acc;
    r = '0;
    done_elems = (done_elems + 1) & CNT_MASK;
    if (done_elems == exp_elems) msg_fin = 1;
    active = 0;
    r.kind = RK_COMPLETE; r.vtype = ety;
    if (ety == TY_INT) r.ival = sv;
    if (ety == TY_DBL) begin
      r.ival = sv; r.fval = facc[59:0]; r.fdig = fcnt; r.bval = neg;
    end
    if (ety == TY_BOOL) r.bval = bool_v;
    r.done = msg_fin;
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic predict_beat(beat_t it);
    logic [7:0] b;
    logic f;
    b = it.b;
    if (it.op == OP_RESTART) begin
      clear_parser();
      return;
    end
    if (err_l || msg_fin) return;
    if (!active) begin
      case (b)
        CH_COLON:  ety = TY_INT;
        CH_COMMA:  ety = TY_DBL;
        CH_HASH:   ety = TY_BOOL;
        CH_UNDER:  ety = TY_NULL;
        CH_PLUS:   ety = TY_SIMPLE;
        CH_DOLLAR: ety = TY_BULK;
        CH_STAR:   ety = TY_ARRAY;
        default: begin
          push_error(ERR_UNKNOWN);
          return;
        end
      endcase
      active = 1; first_byte = 1; neg = 0; acc = 0; in_frac = 0; facc = 0;
      fcnt = 0; bool_v = 0; bphase = BP_LENGTH; remain = 0; eol_left = 2;
      return;
    end
    f = first_byte;
    first_byte = 0;
    case (ety)
      TY_INT: begin
        if (f && b == CH_MINUS) neg = 1;
        else if (b == CH_CR) ;
        else if (b == CH_LF) push_complete();
        else if (!is_dig(b)) push_error(ERR_TOKEN);
        else acc = acc * 10 + (b - CH_0);
      end
      TY_DBL: begin
        if (f && b == CH_MINUS) neg = 1;
        else if (b == CH_CR) ;
        else if (b == CH_LF) push_complete();
        else if (!in_frac && (b == CH_DOT || b == CH_COMMA)) in_frac = 1;
        else if (!is_dig(b)) push_error(ERR_TOKEN);
        else if (in_frac) begin
          if (fcnt < 18) begin
            facc = facc * 10 + (b - CH_0);
            fcnt++;
          end
        end else acc = acc * 10 + (b - CH_0);
      end
      TY_BOOL: begin
        if (f) begin
          if (b == "1" || b == "t" || b == "T") bool_v = 1;
          else if (b == "0" || b == "f" || b == "F") bool_v = 0;
          else push_error(ERR_TOKEN);
        end else if (b == CH_LF) push_complete();
      end
      TY_NULL: begin
        if (b == CH_CR) ;
        else if (b == CH_LF) push_complete();
        else push_error(ERR_TOKEN);
      end
      TY_SIMPLE: begin
        if (eol_left == 1) begin
          if (b == CH_LF) push_complete();
          else push_error(ERR_TOKEN);
        end else if (b == CH_CR) eol_left = 1;
        else if (b == CH_LF) push_complete();
        else push_payload(b);
      end
      TY_BULK: begin
        if (bphase == BP_LENGTH) begin
          if (f && b == CH_MINUS) push_error(ERR_BULK_LEN);
          else if (b == CH_CR) ;
          else if (b == CH_LF) begin
            if (acc > {34'd0, max_len}) push_error(ERR_BULK_LEN);
            else begin
              remain = acc[29:0];
              bphase = (remain != 0) ? BP_DATA : BP_TERM;
            end
          end else if (!is_dig(b)) push_error(ERR_TOKEN);
          else acc = sat_mac(acc, b - CH_0, {34'd0, max_len} + 1);
        end else if (bphase == BP_DATA) begin
          remain = remain - 1;
          if (remain == 0) bphase = BP_TERM;
          push_payload(b);
        end else if (b == CH_CR || b == CH_LF) begin
          if (eol_left > 0) eol_left--;
          if (eol_left == 0) push_complete();
        end else push_error(ERR_TOKEN);
      end
      TY_ARRAY: begin
        if (b == CH_CR) ;
        else if (b == CH_LF) begin
          exp_elems = acc[31:0];
          active = 0;
          if (done_elems == exp_elems) msg_fin = 1;
        end else if (!is_dig(b)) push_error(ERR_TOKEN);
        else acc = sat_mac(acc, b - CH_0, {32'd0, CNT_MASK});
      end
      default: push_error(ERR_TOKEN);
    endcase
  endtask

  // driver
  always @(negedge clk_i) begin
    beat_t nb;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nb = pending_beats.pop_front();
        in_valid_i  <= 1'b1;
        operation_i <= nb.op;
        in_byte_i   <= nb.b;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // prediction on acceptance, monitor on output
  always @(posedge clk_i) begin
    result_t got, want;
    logic hit;
    hit = 0;
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (!rst_ni) clear_parser();
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_beat(beat_t'{operation_i, in_byte_i});
      hit = 1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      hit = 1;
      got = {result_kind_o, value_type_o, integer_value_o, fraction_value_o,
             fraction_digits_o, boolean_value_o, string_byte_o, fault_code_o,
             message_done_o};
      if (expected_results.size() == 0) begin
        $error("unexpected result beat kind=%0d", result_kind_o);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind) begin
          $error("result_kind exp %0d got %0d", want.kind, got.kind); failures++;
        end
        if (got.vtype !== want.vtype) begin
          $error("value_type exp %0d got %0d", want.vtype, got.vtype); failures++;
        end
        if (got.ival !== want.ival) begin
          $error("integer_value exp %0d got %0d", want.ival, got.ival); failures++;
        end
        if (got.fval !== want.fval) begin
          $error("fraction_value exp %0d got %0d", want.fval, got.fval); failures++;
        end
        if (got.fdig !== want.fdig) begin
          $error("fraction_digits exp %0d got %0d", want.fdig, got.fdig); failures++;
        end
        if (got.bval !== want.bval) begin
          $error("boolean_value exp %0d got %0d", want.bval, got.bval); failures++;
        end
        if (got.sbyte !== want.sbyte) begin
          $error("string_byte exp %0h got %0h", want.sbyte, got.sbyte); failures++;
        end
        if (got.ecode !== want.ecode) begin
          $error("fault_code exp %0d got %0d", want.ecode, got.ecode); failures++;
        end
        if (got.done !== want.done) begin
          $error("message_done exp %0d got %0d", want.done, got.done); failures++;
        end
      end
    end
    quiet_cycles <= hit ? 0 : quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic add(logic op, logic [7:0] b);
    pending_beats.insert(pending_beats.size(), beat_t'{op, b});
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) add(OP_BYTE, s[i]);
  endtask

  task automatic add_digits(int n);
    for (int i = 0; i < n; i++) add(OP_BYTE, 8'(CH_0 + $urandom_range(9)));
  endtask

  task automatic add_element();
    int n;
    case ($urandom_range(7))
      0: begin
        add(OP_BYTE, CH_COLON);
        if ($urandom_range(1)) add(OP_BYTE, CH_MINUS);
        add_digits($urandom_range(1, 22)); add_str("\r\n");
      end
      1: begin
        add(OP_BYTE, CH_COMMA);
        if ($urandom_range(1)) add(OP_BYTE, CH_MINUS);
        add_digits($urandom_range(0, 5));
        add(OP_BYTE, $urandom_range(1) ? CH_DOT : CH_COMMA);
        add_digits($urandom_range(0, 21)); add_str("\r\n");
      end
      2: begin
        add(OP_BYTE, CH_HASH); add_str($urandom_range(1) ? "t" : "F");
        add_str("\r\n");
      end
      3: add_str("_\r\n");
      4: begin
        add(OP_BYTE, CH_PLUS);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) add(OP_BYTE, 8'($urandom_range(14, 255)));
        add_str($urandom_range(3) ? "\r\n" : "\n");
      end
      default: begin
        n = $urandom_range(0, 12);
        add(OP_BYTE, CH_DOLLAR); add_str($sformatf("%0d\r\n", n));
        for (int i = 0; i < n; i++) add(OP_BYTE, 8'($urandom_range(255)));
        add_str("\r\n");
      end
    endcase
  endtask

  task automatic wait_drained(int settle);
    while (pending_beats.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_max_len(logic [29:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    max_len = v;
  endtask

  initial begin
    int n;
    max_len = BULK_LEN_RESET;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    add_str("*3\r\n:-42\r\n,-0.5\r\n#T\r\n"); add(OP_RESTART, 8'hFF);
    add_str("+ab\rX"); add(OP_RESTART, 8'h00);
    add_str("$-1"); add(OP_RESTART, 8'h00);
    add_str("@"); add(OP_RESTART, 8'h00);
    add_str("*0\r\n:1"); add(OP_RESTART, 8'h00);
    add_str(",1.2.3\r\n"); add(OP_RESTART, 8'h00);
    add_str("$536870913\r\n"); add(OP_RESTART, 8'h00);
    add_str("$0\r\n\n\n"); add(OP_RESTART, 8'h00);
    add_str(":99999999999999999999999\r\n"); add(OP_RESTART, 8'h00);
    wait_drained(4);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      case (ph)
        1: write_max_len('0);
        2: write_max_len(30'h3FFF_FFFF);
        3: write_max_len(30'd5);
        5: write_max_len(BULK_LEN_RESET);
        default: ;
      endcase
      while (pending_beats.size() < 90) begin
        add(OP_RESTART, 8'($urandom_range(255)));
        if ($urandom_range(9) == 0) begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++)
            add($urandom_range(9) == 0, 8'($urandom_range(255)));
        end else begin
          n = $urandom_range(0, 4);
          if (n > 0) add_str($sformatf("*%0d\r\n", n + ($urandom_range(3) == 0)));
          for (int i = 0; i < (n > 0 ? n : 1); i++) begin
            add_element();
            if ($urandom_range(19) == 0) add(OP_BYTE, 8'($urandom_range(255)));
          end
        end
      end
      wait_drained(4);
    end

    if (failures == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
